FILE: rtl/core/sorted_sparse_vector_store_top_defines.svh
// Assertion macros for the sorted sparse vector store.
// Included by the top level; expects clk and rst_n in scope.
`ifndef SORTED_SPARSE_VECTOR_STORE_TOP_DEFINES_SVH
`define SORTED_SPARSE_VECTOR_STORE_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SSVS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted sparse vector store: assertion failed");

// Invariant checked at every clock, disabled in reset.
`define SSVS_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sorted sparse vector store: invariant violated");

`endif

FILE: rtl/core/ssvs_pkg.sv
// Shared constants, opcodes and structs for the sorted sparse vector store.
// No dependencies.
package ssvs_pkg;

  localparam int CAPACITY    = 32;
  localparam int INDEX_WIDTH = 16;
  localparam int VALUE_WIDTH = 32;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_GET = 2'd1,
    OP_ACC = 2'd2
  } op_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic [INDEX_WIDTH-1:0] key;
    logic [VALUE_WIDTH-1:0] ins_val;
    logic [VALUE_WIDTH-1:0] wr_val;
    logic                   insert_en;
    logic                   write_en;
  } ctrl_t;

  // neighbor link, cell i to cell i+1
  typedef struct packed {
    logic [INDEX_WIDTH-1:0] idx;
    logic [VALUE_WIDTH-1:0] val;
    logic                   occ;
    logic                   below;
  } link_t;

  // lookup summary from the chain
  typedef struct packed {
    logic                   hit_any;
    logic                   full;
    logic [VALUE_WIDTH-1:0] hit_val;
    logic [CAPACITY-1:0]    hit_vec;
    logic [CAPACITY-1:0]    occ_vec;
  } stat_t;

endpackage

FILE: rtl/core/ssvs_if.sv
// Valid/ready channel interfaces for the input and result beats.
// Depends on ssvs_pkg for field widths.
interface ssvs_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          op;
  logic [15:0]                         index;
  logic signed [ssvs_pkg::VALUE_WIDTH-1:0] value;

  modport source (output valid, output op, output index, output value, input ready);
  modport sink   (input valid, input op, input index, input value, output ready);
endinterface

interface ssvs_out_if;
  logic                                valid;
  logic                                ready;
  logic                                present;
  logic signed [ssvs_pkg::VALUE_WIDTH-1:0] read_value;
  logic                                status;

  modport source (output valid, output present, output read_value, output status,
                  input ready);
  modport sink   (input valid, input present, input read_value, input status,
                  output ready);
endinterface

FILE: rtl/core/sorted_sparse_vector_store_top.sv
// Channel    Dir  Payload                            Handshake
// in_bus     in   op[1:0] index[15:0] value[31:0]     valid/ready
// out_bus    out  present read_value[31:0] status     valid/ready
//
// Each beat passes through accept, chain lookup (parallel compare and
// registered hit-value OR), then update with the shared adder and result load.
// rst_n (sync) empties the store by clearing every occupied flag; no clearing pass.
// in_bus.ready is high in idle, also while a finished result waits.
// The update step holds while the output register is full and not taken.
// Depends on ssvs_pkg, ssvs_if, ssvs_chain and the defines header.
`include "sorted_sparse_vector_store_top_defines.svh"

module sorted_sparse_vector_store_top (
  input  logic        clk,
  input  logic        rst_n,
  ssvs_in_if.sink     in_bus,
  ssvs_out_if.source  out_bus
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  state_t                            state_r;
  logic [1:0]                        op_r;
  logic [ssvs_pkg::INDEX_WIDTH-1:0]  key_r;
  logic [ssvs_pkg::VALUE_WIDTH-1:0]  val_r;
  logic [ssvs_pkg::VALUE_WIDTH-1:0]  hitval_r;
  logic                              hit_r;
  logic                              full_r;

  logic                              out_valid_r;
  logic                              out_present_r;
  logic [ssvs_pkg::VALUE_WIDTH-1:0]  out_value_r;
  logic                              out_status_r;

  ssvs_pkg::ctrl_t                   ctrl;
  ssvs_pkg::stat_t                   stat;

  logic                              wr_op;
  logic                              fire;
  logic [ssvs_pkg::VALUE_WIDTH-1:0]  new_val;
  logic [ssvs_pkg::VALUE_WIDTH-1:0]  res_val;

  assign in_bus.ready = (state_r == ST_IDLE);

  assign wr_op   = (op_r == ssvs_pkg::OP_SET) || (op_r == ssvs_pkg::OP_ACC);
  assign fire    = (state_r == ST_UPDATE) && (!out_valid_r || out_bus.ready);
  assign new_val = (op_r == ssvs_pkg::OP_ACC) ? (hitval_r + val_r) : val_r;

  always_comb begin
    if (hit_r) begin
      res_val = wr_op ? new_val : hitval_r;
    end else if (wr_op && !full_r) begin
      res_val = val_r;
    end else begin
      res_val = '0;
    end
  end

  assign ctrl.key       = key_r;
  assign ctrl.ins_val   = val_r;
  assign ctrl.wr_val    = new_val;
  assign ctrl.write_en  = fire && wr_op && hit_r;
  assign ctrl.insert_en = fire && wr_op && !hit_r && !full_r;

  ssvs_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_bus.ready && !fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_bus.valid) begin
            op_r    <= in_bus.op;
            key_r   <= in_bus.index[ssvs_pkg::INDEX_WIDTH-1:0];
            val_r   <= in_bus.value;
            state_r <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          hit_r    <= stat.hit_any;
          full_r   <= stat.full;
          hitval_r <= stat.hit_val;
          state_r  <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (fire) begin
            out_valid_r   <= 1'b1;
            out_present_r <= hit_r;
            out_value_r   <= res_val;
            out_status_r  <= wr_op && !hit_r && full_r;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.present    = out_present_r;
  assign out_bus.read_value = out_value_r;
  assign out_bus.status     = out_status_r;

  `SSVS_ASSERT_ALWAYS(a_hit_onehot, $onehot0(stat.hit_vec))
  `SSVS_ASSERT_ALWAYS(a_occ_prefix, ((stat.occ_vec >> 1) & ~stat.occ_vec) == '0)
  `SSVS_ASSERT_IMPL(a_full_zero, out_valid_r && out_status_r, !out_present_r && (out_value_r == '0))

endmodule

FILE: rtl/core/ssvs_cell.sv
// One slot of the sorted chain: holds index, value and occupied flag.
// Depends on ssvs_pkg; shifts from its left neighbor on insert.
module ssvs_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  ssvs_pkg::ctrl_t ctrl,
  input  ssvs_pkg::link_t left,
  output ssvs_pkg::link_t right,
  output logic           hit
);

  logic [ssvs_pkg::INDEX_WIDTH-1:0] idx_r;
  logic [ssvs_pkg::VALUE_WIDTH-1:0] val_r;
  logic                             occ_r;
  logic                             below;
  logic                             point;

  // sorted prefix: "below" cells are a prefix, first non-below cell is the slot
  assign below = occ_r && (idx_r < ctrl.key);
  assign point = !below && left.below;
  assign hit   = point && occ_r && (idx_r == ctrl.key);

  assign right.idx   = idx_r;
  assign right.val   = val_r;
  assign right.occ   = occ_r;
  assign right.below = below;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (ctrl.insert_en) begin
      if (point) begin
        idx_r <= ctrl.key;
        val_r <= ctrl.ins_val;
        occ_r <= 1'b1;
      end else if (!below) begin
        idx_r <= left.idx;
        val_r <= left.val;
        occ_r <= left.occ;
      end
    end else if (ctrl.write_en && hit) begin
      val_r <= ctrl.wr_val;
    end
  end

endmodule

FILE: rtl/core/ssvs_chain.sv
// Row of CAPACITY cells with the hit-value OR reduction.
// Depends on ssvs_pkg and ssvs_cell.
module ssvs_chain (
  input  logic            clk,
  input  logic            rst_n,
  input  ssvs_pkg::ctrl_t ctrl,
  output ssvs_pkg::stat_t stat
);

  ssvs_pkg::link_t                   link [ssvs_pkg::CAPACITY+1];
  logic [ssvs_pkg::CAPACITY-1:0]     hit_vec;
  logic [ssvs_pkg::VALUE_WIDTH-1:0]  hit_val;

  assign link[0].idx   = '0;
  assign link[0].val   = '0;
  assign link[0].occ   = 1'b0;
  assign link[0].below = 1'b1;

  for (genvar i = 0; i < ssvs_pkg::CAPACITY; i++) begin : g_cell
    ssvs_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .left  (link[i]),
      .right (link[i+1]),
      .hit   (hit_vec[i])
    );
    assign stat.occ_vec[i] = link[i+1].occ;
  end

  always_comb begin
    hit_val = '0;
    for (int i = 0; i < ssvs_pkg::CAPACITY; i++) begin
      hit_val = hit_val | (link[i+1].val & {ssvs_pkg::VALUE_WIDTH{hit_vec[i]}});
    end
  end

  assign stat.hit_any = |hit_vec;
  assign stat.full    = link[ssvs_pkg::CAPACITY].occ && !(|hit_vec);
  assign stat.hit_val = hit_val;
  assign stat.hit_vec = hit_vec;

endmodule
